### hdl/animated_decimal_counter_display_macros.svh
// ----------------------------------------------------------------------------
// animated_decimal_counter_display_macros
// Concurrent assertion shorthands used by the counter display back end.
// ----------------------------------------------------------------------------
`ifndef ANIMATED_DECIMAL_COUNTER_DISPLAY_MACROS_SVH
`define ANIMATED_DECIMAL_COUNTER_DISPLAY_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ADCD_ASSERT_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ADCD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle
`define ADCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/adcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcd_pkg
// Widths, codes and the command format shared by the counter display blocks.
// ----------------------------------------------------------------------------
package adcd_pkg;

	localparam int VALUE_W  = 30;
	localparam int STEPS_W  = 10;
	localparam int ACTION_W = 2;
	localparam int POS_W    = 4;
	localparam int DIGIT_W  = 4;
	localparam int COL_W    = 3;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;

	localparam int DIGIT_COUNT_DEF   = 9;
	localparam int ATLAS_COLUMNS_DEF = 5;
	localparam int QUEUE_DEPTH_DEF   = 2;

	// Input word kinds as they arrive on tuser
	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK = 2'd0,
		ACT_SET  = 2'd1,
		ACT_STEP = 2'd2
	} action_t;

	// Classified commands handed from front to back
	typedef enum logic [1:0] {
		OP_TICK,
		OP_SET,
		OP_LOAD,
		OP_STEP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [VALUE_W-1:0] value;
		logic [STEPS_W-1:0] steps;
	} cmd_t;

	// Largest value shown on the given number of digits
	function automatic logic [VALUE_W-1:0] value_limit(input int digits);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < digits; i++) begin
			p = p * 64'd10;
		end
		return VALUE_W'(p - 64'd1);
	endfunction

endpackage

### hdl/adcd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcd_fifo
// Short register queue that decouples command intake from execution.
// ----------------------------------------------------------------------------
module adcd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (cnt_q != CNT_W'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Store incoming entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hdl/adcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcd_front
// Accepts input words, clamps the value and classifies each into a command.
// ----------------------------------------------------------------------------
module adcd_front import adcd_pkg::*; #(
	parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // value[29:0], steps[39:30]
	input  logic [ACTION_W-1:0]  s_tuser,  // action[1:0]
	output logic                 push_valid,
	input  logic                 push_ready,
	output cmd_t                 push_cmd
);

	localparam logic [VALUE_W-1:0] LIMIT = value_limit(DIGIT_COUNT);

	logic [VALUE_W-1:0] in_value;
	logic [STEPS_W-1:0] in_steps;
	logic [VALUE_W-1:0] clamped;
	logic               keep;

	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_steps = s_tdata[VALUE_W +: STEPS_W];
	assign clamped  = (in_value > LIMIT) ? LIMIT : in_value;

	// Ready follows queue space; unused actions are taken and dropped
	assign s_tready   = push_ready;
	assign push_valid = s_tvalid && keep;

	// Classify the word
	always_comb begin
		keep           = 1'b1;
		push_cmd.op    = OP_TICK;
		push_cmd.value = clamped;
		push_cmd.steps = in_steps;
		case (action_t'(s_tuser))
			ACT_TICK: begin
				push_cmd.op = OP_TICK;
			end
			ACT_SET: begin
				push_cmd.op = OP_SET;
			end
			ACT_STEP: begin
				push_cmd.op = (in_steps <= STEPS_W'(1)) ? OP_LOAD : OP_STEP;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

endmodule

### hdl/adcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcd_back
// Executes commands: serial divide for stepping, serial binary to BCD
// conversion, and digit emission through a registered output stage.
// ----------------------------------------------------------------------------
`include "animated_decimal_counter_display_macros.svh"

module adcd_back import adcd_pkg::*; #(
	parameter int DIGIT_COUNT   = DIGIT_COUNT_DEF,
	parameter int ATLAS_COLUMNS = ATLAS_COLUMNS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  cmd_t                 cmd,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast
);

	localparam logic [VALUE_W-1:0] LIMIT = value_limit(DIGIT_COUNT);
	localparam int BCD_W    = DIGIT_COUNT * DIGIT_W;
	localparam int ITER_W   = $clog2(VALUE_W);
	localparam int FIELDS_W = POS_W + DIGIT_W + COL_W + 2 + VALUE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ACC,
		ST_CONV,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [VALUE_W-1:0]   count_q;
	logic [VALUE_W-1:0]   pend_q;
	logic [STEPS_W-1:0]   div_q;
	logic                 slz_q;
	logic [VALUE_W-1:0]   dvd_q;
	logic [STEPS_W-1:0]   rem_q;
	logic [ITER_W-1:0]    iter_q;
	logic [VALUE_W-1:0]   bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [POS_W-1:0]     pos_q;
	logic                 seen_q;
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;
	logic                 m_tlast_q;

	logic [STEPS_W:0]     rem_shift;
	logic                 ge;
	logic [STEPS_W:0]     rem_next;
	logic [VALUE_W-1:0]   addend;
	logic [VALUE_W:0]     sum;
	logic [VALUE_W-1:0]   sat;
	logic                 pend_gt_div;
	logic [BCD_W-1:0]     bcd_adj;
	logic [BCD_W-1:0]     bcd_shift;
	logic [DIGIT_W-1:0]   out_digit;
	logic                 out_nz;
	logic                 out_last;
	logic                 out_vis;
	logic [COL_W-1:0]     out_col;
	logic                 out_row;
	logic                 load_out;
	logic                 iter_done;

	assign cmd_ready = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tlast   = m_tlast_q;
	assign iter_done = (iter_q == ITER_W'(VALUE_W - 1));

	// One restoring divide step per cycle
	assign rem_shift = {rem_q, dvd_q[VALUE_W-1]};
	assign ge        = (rem_shift >= {1'b0, div_q});
	assign rem_next  = ge ? (rem_shift - {1'b0, div_q}) : rem_shift;

	// Saturating add of the step (quotient or whole remainder)
	assign addend      = (state_q == ST_ACC) ? dvd_q : pend_q;
	assign sum         = {1'b0, count_q} + {1'b0, addend};
	assign sat         = (sum > {1'b0, LIMIT}) ? LIMIT : sum[VALUE_W-1:0];
	assign pend_gt_div = (pend_q > {{(VALUE_W - STEPS_W){1'b0}}, div_q});

	// Double-dabble adjust of each digit, then shift in the next bit
	always_comb begin
		for (int d = 0; d < DIGIT_COUNT; d++) begin
			bcd_adj[d*DIGIT_W +: DIGIT_W] = (bcd_q[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) ?
				bcd_q[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3) : bcd_q[d*DIGIT_W +: DIGIT_W];
		end
	end
	assign bcd_shift = {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};

	// Fields of the digit about to be emitted
	assign out_digit = bcd_q[BCD_W-1 -: DIGIT_W];
	assign out_nz    = (out_digit != '0);
	assign out_last  = (pos_q == POS_W'(DIGIT_COUNT - 1));
	assign out_vis   = out_last || slz_q || seen_q || out_nz;
	assign load_out  = (state_q == ST_EMIT) && (!m_tvalid_q || m_tready);

	// Look up the atlas cell of the digit in a small constant table
	always_comb begin
		out_col = '0;
		out_row = 1'b0;
		for (int dv = 0; dv < (1 << DIGIT_W); dv++) begin
			if (out_digit == DIGIT_W'(dv)) begin
				out_col = COL_W'(dv % ATLAS_COLUMNS);
				out_row = 1'((dv / ATLAS_COLUMNS) & 1);
			end
		end
	end

	// Sequencer, state registers and output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			pend_q     <= '0;
			div_q      <= STEPS_W'(1);
			slz_q      <= 1'b1;
			dvd_q      <= '0;
			rem_q      <= '0;
			iter_q     <= '0;
			bin_q      <= '0;
			bcd_q      <= '0;
			pos_q      <= '0;
			seen_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				slz_q <= cfg_wr_data;
			end
			if (m_tvalid_q && m_tready && !load_out) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.op)
							OP_SET: begin
								count_q <= cmd.value;
								pend_q  <= '0;
								div_q   <= STEPS_W'(1);
							end
							OP_LOAD: begin
								count_q <= cmd.value;
							end
							OP_STEP: begin
								pend_q <= cmd.value;
								div_q  <= cmd.steps;
							end
							OP_TICK: begin
								iter_q <= '0;
								if (pend_q == '0) begin
									bin_q   <= count_q;
									bcd_q   <= '0;
									state_q <= ST_CONV;
								end else if (pend_gt_div) begin
									dvd_q   <= pend_q;
									rem_q   <= '0;
									state_q <= ST_DIV;
								end else begin
									count_q <= sat;
									pend_q  <= '0;
									bin_q   <= sat;
									bcd_q   <= '0;
									state_q <= ST_CONV;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DIV: begin
					rem_q  <= rem_next[STEPS_W-1:0];
					dvd_q  <= {dvd_q[VALUE_W-2:0], ge};
					iter_q <= iter_q + 1'b1;
					if (iter_done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					count_q <= sat;
					pend_q  <= pend_q - dvd_q;
					bin_q   <= sat;
					bcd_q   <= '0;
					iter_q  <= '0;
					state_q <= ST_CONV;
				end
				ST_CONV: begin
					bcd_q  <= bcd_shift;
					bin_q  <= bin_q << 1;
					iter_q <= iter_q + 1'b1;
					if (iter_done) begin
						pos_q   <= '0;
						seen_q  <= 1'b0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {{(M_TDATA_W - FIELDS_W){1'b0}}, count_q, out_vis,
							out_row, out_col, out_digit, pos_q};
						m_tlast_q  <= out_last;
						bcd_q      <= bcd_q << DIGIT_W;
						pos_q      <= pos_q + 1'b1;
						seen_q     <= seen_q || out_nz;
						if (out_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ADCD_ASSERT_HOLDS(a_count_in_range, count_q <= LIMIT, "shown count above limit")
	`ADCD_ASSERT_IMPLIES(a_div_only_when_larger, state_q == ST_DIV,
		pend_gt_div && (div_q != '0), "divide entered without increment above divisor")
	`ADCD_ASSERT_IMPLIES(a_last_slot, m_tvalid && m_tlast,
		m_tdata[POS_W-1:0] == POS_W'(DIGIT_COUNT - 1), "end of run on wrong slot")
	`ADCD_ASSERT_NEXT(a_run_closes, load_out && out_last,
		(state_q == ST_IDLE) && m_tvalid, "last digit did not close the run")

endmodule

### hdl/animated_decimal_counter_display.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animated_decimal_counter_display
// Stepped decimal counter that emits its digits with sprite atlas cells.
// ----------------------------------------------------------------------------
// Input words arrive on s_t*: tuser carries the action, tdata the value and
// step count. Set and step words change state and produce nothing; each tick word
// produces DIGIT_COUNT output words on m_t*, most significant slot first,
// with tlast on the least significant slot. show_leading_zeros is to be
// written through cfg_wr_en / cfg_wr_data only while the block is idle;
// the block itself does not enforce this. A front stage classifies and
// clamps words into a short command queue, accepting one word per cycle
// while the queue has room. The back end takes one command at a time and
// takes no new one until it is back in idle. A tick starts in idle, runs a
// serial divide when the pending increment is larger than the step divisor
// (one quotient bit per cycle, then an accumulate step), converts the
// count from binary to BCD serially, then emits one output word per digit
// as the receiver takes them. Reset clears the count and increment, sets
// the divisor to one and shows leading zeros. A stalled receiver holds the
// output register; the back end waits and the queue then fills before
// s_tready drops.
// ----------------------------------------------------------------------------
module animated_decimal_counter_display import adcd_pkg::*; #(
	parameter int DIGIT_COUNT   = DIGIT_COUNT_DEF,
	parameter int ATLAS_COLUMNS = ATLAS_COLUMNS_DEF,
	parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic                 cfg_wr_data,  // show_leading_zeros
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,      // value[29:0], steps[39:30]
	input  logic [ACTION_W-1:0]  s_tuser,      // action[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// digit_position[3:0], digit[7:4], atlas_column[10:8], atlas_row[11],
	// visible[12], shown_total[42:13], zero fill[47:43]
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic                 m_tlast       // last_digit
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	adcd_front #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	adcd_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_data (push_cmd),
		.rd_valid(pop_valid),
		.rd_ready(pop_ready),
		.rd_data (pop_cmd)
	);

	adcd_back #(
		.DIGIT_COUNT  (DIGIT_COUNT),
		.ATLAS_COLUMNS(ATLAS_COLUMNS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd_valid  (pop_valid),
		.cmd_ready  (pop_ready),
		.cmd        (pop_cmd),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
